// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/ssh_pd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pd_pkg
// Types and constants of the SSH packet deframer.
// ----------------------------------------------------------------------------
package ssh_pd_pkg;

  localparam int unsigned MaxLenW       = 25;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned SeqW          = 32;
  localparam logic [MaxLenW-1:0] MaxLenReset = 25'd19936;
  localparam logic [7:0] MsgIgnore      = 8'd2;
  localparam logic [7:0] MsgDebug       = 8'd4;

  localparam logic [CfgIdxW-1:0] CfgMaxLength    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFilterEnable = 2'd1;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindBadLen  = 2'd1;
  localparam logic [1:0] KindBadPad  = 2'd2;
  localparam logic [1:0] KindEmpty   = 2'd3;

  typedef enum logic [2:0] {
    PhLen,
    PhPadLen,
    PhPayload,
    PhPadding,
    PhHalt
  } phase_e;

  typedef struct packed {
    logic            valid;
    logic [7:0]      out_byte;
    logic [1:0]      kind;
    logic            last_byte;
    logic [SeqW-1:0] packet_seq;
  } result_t;

endpackage

// ===== rtl/ssh_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// ssh_packet_deframer
// Plaintext SSH binary packet deframer: length and padding checks, payload
// extraction, sequence numbering and ignore/debug filtering.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid_i/rx_ready_o, rx_byte_i) takes one received byte per
//   transfer. out channel (out_valid_o/out_ready_i) carries payload bytes,
//   error codes and empty-packet markers with the packet sequence number.
//   Padding and filtered packets produce no transfer.
//   A byte's result reaches the out channel through the input register,
//   then the result register. Throughput: one byte per cycle while the
//   receiver does not stall, with the deframing state machine between the
//   input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register fills; rx_ready_o drops only when both are occupied.
//   A length or padding error is reported once; the block then consumes and
//   drops every byte until reset.
//   Reset clears the sequence number, returns to length collection and loads
//   max_length = 19936 and filter_enable = 1. Write configuration while idle.
// ----------------------------------------------------------------------------
module ssh_packet_deframer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ssh_pd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ssh_pd_pkg::MaxLenW-1:0]  cfg_wdata_i,
  input  logic                            rx_valid_i,
  output logic                            rx_ready_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic [1:0]                      kind_o,
  output logic                            last_byte_o,
  output logic [ssh_pd_pkg::SeqW-1:0]     packet_seq_o
);

  logic [ssh_pd_pkg::MaxLenW-1:0] max_len_q;
  logic                           filt_q;
  logic                           in_valid_q;
  logic [7:0]                     in_byte_q;
  logic                           out_valid_q;
  ssh_pd_pkg::result_t            out_q;
  ssh_pd_pkg::result_t            res;
  logic                           advance;
  logic                           step;

  assign advance    = !out_valid_q || out_ready_i;
  assign rx_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ssh_pd_pkg::MaxLenReset;
      filt_q    <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ssh_pd_pkg::CfgMaxLength) begin
        max_len_q <= cfg_wdata_i;
      end else if (cfg_index_i == ssh_pd_pkg::CfgFilterEnable) begin
        filt_q <= cfg_wdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ready_o && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ssh_pd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .rx_byte_i       (in_byte_q),
    .max_length_i    (max_len_q),
    .filter_enable_i (filt_q),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_q.out_byte;
  assign kind_o       = out_q.kind;
  assign last_byte_o  = out_q.last_byte;
  assign packet_seq_o = out_q.packet_seq;

endmodule

// ===== rtl/ssh_pd_core.sv =====
// ----------------------------------------------------------------------------
// ssh_pd_core
// Deframing state machine: consumes one byte per step, produces at most one
// result for it.
// ----------------------------------------------------------------------------
module ssh_pd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic [ssh_pd_pkg::MaxLenW-1:0]  max_length_i,
  input  logic                            filter_enable_i,
  output ssh_pd_pkg::result_t             res_o
);

  ssh_pd_pkg::phase_e phase_q, phase_d;
  logic [31:0]                     acc_q, acc_d;
  logic [1:0]                      len_cnt_q, len_cnt_d;
  logic [ssh_pd_pkg::MaxLenW-1:0]  rem_q, rem_d;
  logic [7:0]                      pad_q, pad_d;
  logic [ssh_pd_pkg::SeqW-1:0]     seq_q, seq_d;
  logic                            disc_q, disc_d;
  logic                            first_q, first_d;

  logic [ssh_pd_pkg::MaxLenW-1:0]  len;
  logic [ssh_pd_pkg::MaxLenW-1:0]  rem_new;
  logic [31:0]                     acc_shift;
  logic                            disc_now;

  assign len       = acc_q[ssh_pd_pkg::MaxLenW-1:0];
  assign rem_new   = len - {{(ssh_pd_pkg::MaxLenW-1){1'b0}}, 1'b1}
                     - {{(ssh_pd_pkg::MaxLenW-8){1'b0}}, rx_byte_i};
  assign acc_shift = {acc_q[23:0], rx_byte_i};
  assign disc_now  = first_q ? (filter_enable_i && (rx_byte_i == ssh_pd_pkg::MsgIgnore ||
                                                    rx_byte_i == ssh_pd_pkg::MsgDebug))
                             : disc_q;

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    len_cnt_d = len_cnt_q;
    rem_d     = rem_q;
    pad_d     = pad_q;
    seq_d     = seq_q;
    disc_d    = disc_q;
    first_d   = first_q;
    res_o            = '0;
    res_o.packet_seq = seq_q;
    if (step_i) begin
      unique case (phase_q)
        ssh_pd_pkg::PhLen: begin
          acc_d     = acc_shift;
          len_cnt_d = len_cnt_q + 2'd1;
          if (len_cnt_q == 2'd3) begin
            if (acc_shift == 32'd0 ||
                acc_shift > {{(32-ssh_pd_pkg::MaxLenW){1'b0}}, max_length_i}) begin
              phase_d    = ssh_pd_pkg::PhHalt;
              res_o.valid = 1'b1;
              res_o.kind  = ssh_pd_pkg::KindBadLen;
            end else begin
              phase_d = ssh_pd_pkg::PhPadLen;
            end
          end
        end
        ssh_pd_pkg::PhPadLen: begin
          if ({{(ssh_pd_pkg::MaxLenW-8){1'b0}}, rx_byte_i} >= len) begin
            phase_d     = ssh_pd_pkg::PhHalt;
            res_o.valid = 1'b1;
            res_o.kind  = ssh_pd_pkg::KindBadPad;
          end else begin
            pad_d   = rx_byte_i;
            rem_d   = rem_new;
            disc_d  = 1'b0;
            first_d = 1'b1;
            if (rem_new == '0) begin
              res_o.valid     = 1'b1;
              res_o.kind      = ssh_pd_pkg::KindEmpty;
              res_o.last_byte = 1'b1;
              if (rx_byte_i == 8'd0) begin
                phase_d   = ssh_pd_pkg::PhLen;
                seq_d     = seq_q + 32'd1;
                acc_d     = '0;
                len_cnt_d = '0;
              end else begin
                phase_d = ssh_pd_pkg::PhPadding;
              end
            end else begin
              phase_d = ssh_pd_pkg::PhPayload;
            end
          end
        end
        ssh_pd_pkg::PhPayload: begin
          disc_d  = disc_now;
          first_d = 1'b0;
          rem_d   = rem_q - {{(ssh_pd_pkg::MaxLenW-1){1'b0}}, 1'b1};
          if (!disc_now) begin
            res_o.valid     = 1'b1;
            res_o.out_byte  = rx_byte_i;
            res_o.kind      = ssh_pd_pkg::KindPayload;
            res_o.last_byte = (rem_q == {{(ssh_pd_pkg::MaxLenW-1){1'b0}}, 1'b1});
          end
          if (rem_q == {{(ssh_pd_pkg::MaxLenW-1){1'b0}}, 1'b1}) begin
            if (pad_q == 8'd0) begin
              phase_d   = ssh_pd_pkg::PhLen;
              seq_d     = seq_q + 32'd1;
              acc_d     = '0;
              len_cnt_d = '0;
            end else begin
              phase_d = ssh_pd_pkg::PhPadding;
            end
          end
        end
        ssh_pd_pkg::PhPadding: begin
          pad_d = pad_q - 8'd1;
          if (pad_q == 8'd1) begin
            phase_d   = ssh_pd_pkg::PhLen;
            seq_d     = seq_q + 32'd1;
            acc_d     = '0;
            len_cnt_d = '0;
          end
        end
        ssh_pd_pkg::PhHalt: begin
          phase_d = ssh_pd_pkg::PhHalt;
        end
        default: begin
          phase_d = ssh_pd_pkg::PhHalt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ssh_pd_pkg::PhLen;
      acc_q     <= '0;
      len_cnt_q <= '0;
      rem_q     <= '0;
      pad_q     <= '0;
      seq_q     <= '0;
      disc_q    <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      len_cnt_q <= len_cnt_d;
      rem_q     <= rem_d;
      pad_q     <= pad_d;
      seq_q     <= seq_d;
      disc_q    <= disc_d;
      first_q   <= first_d;
    end
  end

endmodule

// ===== rtl/ssh_pd_checker.sv =====
// ----------------------------------------------------------------------------
// ssh_pd_checker
// Port-level checks of the SSH packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssh_pd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [7:0]                  out_byte_o,
  input logic [1:0]                  kind_o,
  input logic                        last_byte_o,
  input logic [ssh_pd_pkg::SeqW-1:0] packet_seq_o
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(kind_o) && $stable(packet_seq_o))

  `ASSERT_CLK(a_byte_zero, clk_i, rst_ni, out_valid_o && kind_o != ssh_pd_pkg::KindPayload |-> out_byte_o == 8'd0)

  `ASSERT_CLK(a_err_last, clk_i, rst_ni, out_valid_o && (kind_o == ssh_pd_pkg::KindBadLen || kind_o == ssh_pd_pkg::KindBadPad) |-> !last_byte_o)

  `ASSERT_CLK(a_halt_after_err, clk_i, rst_ni, out_valid_o && out_ready_i && (kind_o == ssh_pd_pkg::KindBadLen || kind_o == ssh_pd_pkg::KindBadPad) |=> !out_valid_o)

endmodule

bind ssh_packet_deframer ssh_pd_checker u_ssh_pd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .kind_o       (kind_o),
  .last_byte_o  (last_byte_o),
  .packet_seq_o (packet_seq_o)
);

// ===== tb/sv/ssh_packet_deframer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssh_packet_deframer_tb
// Self-checking testbench for the SSH packet deframer. Byte streams of
// well-formed packets (empty, padded, filtered, at the length limit) are
// pushed through the rx channel under random backpressure on both sides. A
// behavioral model of the deframer predicts each output transfer, and a
// monitor compares every field in order. The run ends with a length or
// padding error and checks that the block stays silent afterwards.
// ----------------------------------------------------------------------------
module ssh_packet_deframer_tb;
  import ssh_pd_pkg::*;

  localparam int unsigned CyclesLimit = 200000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned EndCycles   = 8;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare3 = 2'd3;

  typedef struct packed {
    logic [7:0]      data;
    logic [1:0]      kind;
    logic            last;
    logic [SeqW-1:0] seq;
  } deframe_res_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [MaxLenW-1:0] cfg_wdata_i = '0;
  logic               rx_valid_i  = 1'b0;
  logic               rx_ready_o;
  logic [7:0]         rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic [1:0]         kind_o;
  logic               last_byte_o;
  logic [SeqW-1:0]    packet_seq_o;

  ssh_packet_deframer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .last_byte_o  (last_byte_o),
    .packet_seq_o (packet_seq_o)
  );

  // deframer model state
  phase_e             ph        = PhLen;
  logic [31:0]        len_acc   = '0;
  logic [31:0]        byte_left = '0;
  logic [7:0]         pad_left  = '0;
  logic [SeqW-1:0]    seq_count = '0;
  logic               discard   = 1'b0;
  logic [MaxLenW-1:0] max_len   = MaxLenReset;
  logic               filt      = 1'b1;

  deframe_res_t pending_results[$];
  int unsigned  mismatch_cnt  = 0;
  int unsigned  rx_byte_cnt   = 0;
  int unsigned  cycle_cnt     = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CyclesLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99, 0) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h want 0x%0h at cycle %0d", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : check_result
    deframe_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(kind_o), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_byte_o != want.data)
          report_mismatch("out_byte", 32'(out_byte_o), 32'(want.data));
        if (kind_o != want.kind)
          report_mismatch("kind", 32'(kind_o), 32'(want.kind));
        if (last_byte_o != want.last)
          report_mismatch("last_byte", 32'(last_byte_o), 32'(want.last));
        if (packet_seq_o != want.seq)
          report_mismatch("packet_seq", packet_seq_o, want.seq);
      end
    end
  end

  task automatic push_result(input logic [7:0] data, input logic [1:0] kind,
                             input logic last);
    deframe_res_t r;
    r.data = data;
    r.kind = kind;
    r.last = last;
    r.seq  = seq_count;
    pending_results.push_back(r);
  endtask

  task automatic close_packet();
    seq_count = seq_count + 1;
    ph        = PhLen;
    byte_left = '0;
    len_acc   = '0;
    pad_left  = '0;
    discard   = 1'b0;
  endtask

  task automatic deframe_predict(input logic [7:0] b);
    logic first;
    case (ph)
      PhLen: begin
        len_acc   = {len_acc[23:0], b};
        byte_left = byte_left + 1;
        if (byte_left >= 4) begin
          if (len_acc < 1 || len_acc > {7'd0, max_len}) begin
            ph = PhHalt;
            push_result(8'd0, KindBadLen, 1'b0);
          end else begin
            byte_left = '0;
            ph        = PhPadLen;
          end
        end
      end
      PhPadLen: begin
        if ({24'd0, b} + 32'd1 > len_acc) begin
          ph = PhHalt;
          push_result(8'd0, KindBadPad, 1'b0);
        end else begin
          pad_left  = b;
          byte_left = len_acc - 1 - {24'd0, b};
          discard   = 1'b0;
          if (byte_left == 0) begin
            push_result(8'd0, KindEmpty, 1'b1);
            if (pad_left == 0) close_packet();
            else ph = PhPadding;
          end else begin
            ph = PhPayload;
          end
        end
      end
      PhPayload: begin
        first = (byte_left == len_acc - 1 - {24'd0, pad_left});
        if (first) discard = filt && (b == MsgIgnore || b == MsgDebug);
        byte_left = byte_left - 1;
        if (!discard) push_result(b, KindPayload, byte_left == 0);
        if (byte_left == 0) begin
          if (pad_left == 0) close_packet();
          else ph = PhPadding;
        end
      end
      PhPadding: begin
        if (pad_left > 0) pad_left = pad_left - 1;
        if (pad_left == 0) close_packet();
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      rx_valid_i = 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    deframe_predict(b);
    rx_byte_cnt++;
  endtask

  // hold the rx channel idle until every expected transfer is out
  task automatic wait_idle();
    @(negedge clk_i);
    rx_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [MaxLenW-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgMaxLength) max_len = data;
    else if (idx == CfgFilterEnable) filt = data[0];
  endtask

  task automatic send_packet(input logic [31:0] len, input logic [7:0] pad,
                             input logic [7:0] msg_type);
    int unsigned body;
    body = len - 1 - pad;
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    send_byte(pad);
    for (int unsigned i = 0; i < body; i++) send_byte(i == 0 ? msg_type : 8'($urandom));
    for (int unsigned i = 0; i < pad; i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_packet();
    logic [31:0] len;
    logic [7:0]  pad;
    logic [7:0]  msg;
    int unsigned cap;
    int unsigned sel;
    cap = (max_len < 300) ? max_len : 300;
    sel = $urandom_range(99, 0);
    if (sel < 3) len = cap;
    else if (sel < 8 && cap >= 256) len = $urandom_range(cap, 256);
    else if (sel < 30 && cap >= 80) len = $urandom_range(80, 25);
    else len = $urandom_range(24, 1);
    if (len >= 256) pad = $urandom_range(255, 200);
    else pad = $urandom_range((len - 1 < 15) ? len - 1 : 15, 0);
    sel = $urandom_range(99, 0);
    if (sel < 20) msg = MsgIgnore;
    else if (sel < 35) msg = MsgDebug;
    else msg = 8'($urandom);
    send_packet(len, pad, msg);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_framing();
    send_packet(32'd1, 8'd0, 8'h00);
    send_packet(32'd4, 8'd3, 8'h00);
    send_packet(32'd2, 8'd0, 8'hFF);
    send_packet(32'd6, 8'd2, 8'h00);
  endtask

  task automatic test_filter();
    send_packet(32'd3, 8'd0, MsgIgnore);
    send_packet(32'd4, 8'd1, MsgDebug);
    send_packet(32'd3, 8'd0, 8'd3);
    send_packet(32'd2, 8'd1, MsgIgnore);
    cfg_write(CfgFilterEnable, 25'h1FFFFFE);
    send_packet(32'd3, 8'd0, MsgIgnore);
    send_packet(32'd3, 8'd0, MsgDebug);
    cfg_write(CfgSpare2, '1);
    cfg_write(CfgSpare3, '1);
    send_packet(32'd3, 8'd0, MsgIgnore);
    cfg_write(CfgFilterEnable, 25'd1);
  endtask

  task automatic test_max_length();
    cfg_write(CfgMaxLength, 25'd1);
    send_packet(32'd1, 8'd0, 8'h00);
    cfg_write(CfgMaxLength, 25'd37);
    send_packet(32'd37, 8'd0, 8'h80);
    cfg_write(CfgMaxLength, 25'd16777216);
    send_packet(32'd9, 8'd4, 8'h7F);
    cfg_write(CfgMaxLength, 25'd300);
    send_packet(32'd300, 8'd255, 8'hAA);
  endtask

  task automatic test_random(input int unsigned n_bytes);
    int unsigned stop_at;
    case ($urandom_range(2, 0))
      0: cfg_write(CfgMaxLength, 25'd300);
      1: cfg_write(CfgMaxLength, MaxLenReset);
      default: cfg_write(CfgMaxLength, 25'd16777216);
    endcase
    cfg_write(CfgFilterEnable, 25'($urandom_range(1, 0)));
    stop_at = rx_byte_cnt + n_bytes;
    while (rx_byte_cnt < stop_at) begin
      send_random_packet();
      // drop into a full drain now and then
      if ($urandom_range(19, 0) == 0) wait_idle();
    end
  endtask

  task automatic test_halt();
    logic [31:0] len;
    case ($urandom_range(2, 0))
      0: len = 32'd0;
      1: len = {7'd0, max_len} + 1;
      default: len = $urandom_range(20, 1);
    endcase
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (ph == PhPadLen) send_byte(8'($urandom_range(255, len)));
    send_packet(32'd8, 8'd0, 8'h11);
    send_packet(32'd1, 8'd0, 8'h00);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    set_idling(33, 65);
    test_framing();
    test_filter();
    test_max_length();
    test_random(150);

    set_idling(65, 33);
    test_random(150);

    set_idling(0, 0);
    test_random(150);
    test_halt();

    @(negedge clk_i);
    rx_valid_i = 1'b0;
    for (int n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk_i);
    repeat (EndCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never seen", pending_results.size(), 32'd0);

    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
